// File: sv/dsmc_pkg.sv
// Shared types, constants and helper functions of the shuttle motor controller.
`default_nettype none

package dsmc_pkg;

	// Width of every debounce counter; a counter saturates at its all-ones value.
	localparam int CNT_W = 8;
	// Width of a configuration register and of the configuration write data.
	localparam int CFG_W = 8;
	// Width used to compare a register value against the counter range.
	localparam int THR_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	// Width of the configuration register index.
	localparam int IDX_W = 2;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	// Register indexes of the configuration port.
	localparam logic [IDX_W-1:0] REG_KEY_TICKS    = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_SENSOR_TICKS = IDX_W'(1);

	// Register values after reset.
	localparam logic [CFG_W-1:0] KEY_TICKS_RST    = CFG_W'(10);
	localparam logic [CFG_W-1:0] SENSOR_TICKS_RST = CFG_W'(5);

	// Debounced flags of the three inputs after the current sample.
	typedef struct packed {
		logic key;
		logic limit_a;
		logic limit_b;
	} flags_t;

	// Motor drive state after the current sample.
	typedef struct packed {
		logic forward;
		logic reverse;
	} drive_t;

	// A register value of zero acts as one, and values beyond the counter
	// range are clamped to the counter's maximum.
	function automatic logic [CNT_W-1:0] thresh(input logic [CFG_W-1:0] n);
		logic [THR_W-1:0] t;
		t = THR_W'(n);
		if (n == '0) t = THR_W'(1);
		if (t > THR_W'(COUNT_MAX)) t = THR_W'(COUNT_MAX);
		return t[CNT_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: sv/dsmc_debounce.sv
// Counting debouncer for one active-low raw input.
`default_nettype none

module dsmc_debounce import dsmc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             tick,
	input  wire logic             level,
	input  wire logic [CFG_W-1:0] ticks,
	output logic                  flag_d
);

	logic             phase_q, phase_d;
	logic [CNT_W-1:0] lo_q, lo_d, hi_q, hi_d;
	logic             flag_q;
	logic [CNT_W-1:0] thr, lo_inc, hi_inc;

	assign thr    = thresh(ticks);
	assign lo_inc = (lo_q < COUNT_MAX) ? lo_q + CNT_W'(1) : lo_q;
	assign hi_inc = (hi_q < COUNT_MAX) ? hi_q + CNT_W'(1) : hi_q;

	// Phase 0 counts low samples, phase 1 counts high samples; the sample
	// that changes the level only switches the phase and clears both counts.
	always_comb begin
		phase_d = phase_q;
		lo_d    = lo_q;
		hi_d    = hi_q;
		flag_d  = flag_q;
		if (!phase_q) begin
			if (!level) begin
				lo_d = lo_inc;
				if (lo_inc >= thr) begin
					flag_d = 1'b1;
					lo_d   = '0;
				end
			end else begin
				phase_d = 1'b1;
				lo_d    = '0;
				hi_d    = '0;
			end
		end else begin
			if (level) begin
				hi_d = hi_inc;
				if (hi_inc >= thr) begin
					flag_d = 1'b0;
					hi_d   = '0;
				end
			end else begin
				phase_d = 1'b0;
				lo_d    = '0;
				hi_d    = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			lo_q    <= '0;
			hi_q    <= '0;
			flag_q  <= 1'b0;
		end else if (tick) begin
			phase_q <= phase_d;
			lo_q    <= lo_d;
			hi_q    <= hi_d;
			flag_q  <= flag_d;
		end
	end

endmodule

`default_nettype wire

// File: sv/dsmc_shuttle.sv
// Key release detector and alternating run control of the shuttle motor.
`default_nettype none

module dsmc_shuttle import dsmc_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   tick,
	input  wire flags_t flags,
	output drive_t      drive_d
);

	logic await_q, await_d;
	logic run_q, run_d;
	logic toward_b_q, toward_b_d;

	always_comb begin
		await_d    = await_q;
		run_d      = run_q;
		toward_b_d = toward_b_q;

		// A press arms the detector; the following release starts a run.
		if (!await_q) begin
			if (flags.key) await_d = 1'b1;
		end else if (!flags.key) begin
			run_d   = 1'b1;
			await_d = 1'b0;
		end

		// A run ends at the limit it heads for, and the next run turns around.
		if (run_d) begin
			if (!toward_b_q) begin
				if (flags.limit_a) begin
					run_d      = 1'b0;
					toward_b_d = 1'b1;
				end
			end else if (flags.limit_b) begin
				run_d      = 1'b0;
				toward_b_d = 1'b0;
			end
		end

		drive_d.forward = run_d && !toward_b_d;
		drive_d.reverse = run_d && toward_b_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			await_q    <= 1'b0;
			run_q      <= 1'b0;
			toward_b_q <= 1'b0;
		end else if (tick) begin
			await_q    <= await_d;
			run_q      <= run_d;
			toward_b_q <= toward_b_d;
		end
	end

endmodule

`default_nettype wire

// File: sv/debounced_shuttle_motor_controller.sv
// Top level of the debounced shuttle motor controller.
`default_nettype none

// Each input transfer is one sample tick of three active-low raw pins: the
// start key and the two limit sensors. Every transfer produces exactly one
// result transfer carrying the motor drive state and the three debounced
// flags as they stand after that tick. The block takes one sample per clock
// cycle for as long as results are taken; a sample goes into an input
// register, and the debounce counters, the key release detector and the run
// control are all updated in the single cycle in which it moves into the
// result register. Because the input register and the result register are
// separate, a new sample can be taken while a finished result still waits.
// The two debounce thresholds are written through the configuration port
// (register 0 for the key, register 1 for both sensors) and must only be
// changed while no sample is in flight. A threshold of zero behaves as one.
// The first run after reset goes forward toward limit A, and each run
// alternates direction.
module debounced_shuttle_motor_controller import dsmc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,

	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,

	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             key_level,
	input  wire logic             limit_a_level,
	input  wire logic             limit_b_level,

	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  drive_forward,
	output logic                  drive_reverse,
	output logic                  key_debounced,
	output logic                  limit_a_active,
	output logic                  limit_b_active
);

	// Threshold registers.
	logic [CFG_W-1:0] key_ticks_q;
	logic [CFG_W-1:0] sensor_ticks_q;

	// Input register stage.
	logic valid_s1;
	logic key_s1, limit_a_s1, limit_b_s1;

	// The sample in the input register is processed when the result register
	// is free or is being emptied in this cycle.
	logic   advance;
	flags_t flags_d;
	drive_t drive_d;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_ticks_q    <= KEY_TICKS_RST;
			sensor_ticks_q <= SENSOR_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_TICKS:    key_ticks_q    <= cfg_data;
				REG_SENSOR_TICKS: sensor_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			key_s1     <= key_level;
			limit_a_s1 <= limit_a_level;
			limit_b_s1 <= limit_b_level;
		end
	end

	// One debouncer per raw input; both sensors share one threshold.
	dsmc_debounce u_key_deb (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (advance),
		.level  (key_s1),
		.ticks  (key_ticks_q),
		.flag_d (flags_d.key)
	);

	dsmc_debounce u_limit_a_deb (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (advance),
		.level  (limit_a_s1),
		.ticks  (sensor_ticks_q),
		.flag_d (flags_d.limit_a)
	);

	dsmc_debounce u_limit_b_deb (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (advance),
		.level  (limit_b_s1),
		.ticks  (sensor_ticks_q),
		.flag_d (flags_d.limit_b)
	);

	dsmc_shuttle u_shuttle (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (advance),
		.flags   (flags_d),
		.drive_d (drive_d)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_forward  <= drive_d.forward;
			drive_reverse  <= drive_d.reverse;
			key_debounced  <= flags_d.key;
			limit_a_active <= flags_d.limit_a;
			limit_b_active <= flags_d.limit_b;
		end
	end

	// The motor is never driven both ways at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(drive_forward && drive_reverse))
		else $error("forward and reverse drive both on");

	// A reported forward drive means limit A was not active in that tick.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && drive_forward) |-> !limit_a_active)
		else $error("forward drive on with limit A active");

	// A reported reverse drive means limit B was not active in that tick.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && drive_reverse) |-> !limit_b_active)
		else $error("reverse drive on with limit B active");

	// A processed sample always lands in the result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("processed sample lost");

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the debounced shuttle motor controller.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dsmc_pkg::*;

	// Settling wait once every result is taken. The block holds one sample in
	// its input stage and one result.
	localparam int unsigned DRAIN_CYCLES = 4;
	// Long receiver hold-off that fills both stages and stalls the input side.
	localparam int unsigned HOLD_OFF_AT = 120;
	localparam int unsigned HOLD_OFF_CYCLES = 60;

	// One raw sample of the three active-low pins.
	typedef struct packed {
		logic key;
		logic limit_a;
		logic limit_b;
	} pin_sample_t;

	// Everything one result transfer carries.
	typedef struct packed {
		drive_t drive;
		flags_t flags;
	} tick_result_t;

	// Counting debouncer of one pin. The phase tells which level is being
	// counted: 0 counts low samples, 1 counts high samples.
	typedef struct packed {
		logic             phase;
		logic [CNT_W-1:0] low_run;
		logic [CNT_W-1:0] high_run;
		logic             flag;
	} debouncer_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             key_level = 1'b1;
	logic             limit_a_level = 1'b1;
	logic             limit_b_level = 1'b1;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic             drive_forward;
	logic             drive_reverse;
	logic             key_debounced;
	logic             limit_a_active;
	logic             limit_b_active;

	debounced_shuttle_motor_controller uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.key_level      (key_level),
		.limit_a_level  (limit_a_level),
		.limit_b_level  (limit_b_level),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.drive_forward  (drive_forward),
		.drive_reverse  (drive_reverse),
		.key_debounced  (key_debounced),
		.limit_a_active (limit_a_active),
		.limit_b_active (limit_b_active)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Thresholds as the block holds them; they change only while it is idle.
	logic [CFG_W-1:0] key_ticks_cfg = KEY_TICKS_RST;
	logic [CFG_W-1:0] sensor_ticks_cfg = SENSOR_TICKS_RST;

	// Predicted controller state, starting from its reset values.
	debouncer_t key_db = '0;
	debouncer_t limit_a_db = '0;
	debouncer_t limit_b_db = '0;
	logic       awaiting_release = 1'b0;
	logic       running = 1'b0;
	logic       heading_b = 1'b0;

	pin_sample_t  pending_samples[$];
	tick_result_t expected_results[$];
	pin_sample_t  offered;
	tick_result_t awaited;

	int unsigned samples_queued = 0;
	int unsigned samples_sent = 0;
	int unsigned error_count = 0;
	int unsigned send_gap = 0;
	int unsigned stall_left = 0;
	logic        idle_bursts = 1'b1;
	logic        hold_off = 1'b0;
	// Direction the stimulus expects the next run to take.
	logic        aim_b = 1'b0;

	// A zero register acts as one; larger values are clamped to the counter range.
	function automatic logic [CNT_W-1:0] ticks_needed(input logic [CFG_W-1:0] n);
		int unsigned t;
		t = (n == '0) ? 1 : int'(n);
		if (t > int'(COUNT_MAX)) t = int'(COUNT_MAX);
		return CNT_W'(t);
	endfunction

	// One sample through a debouncer. The sample that changes the level only
	// switches the phase and restarts both counts; it is not counted itself.
	function automatic debouncer_t debounce_sample(input debouncer_t s, input logic level,
			input logic [CNT_W-1:0] need);
		if (!s.phase) begin
			if (!level) begin
				if (s.low_run != COUNT_MAX) s.low_run++;
				if (s.low_run >= need) begin
					s.flag = 1'b1;
					s.low_run = '0;
				end
			end else begin
				s.phase = 1'b1;
				s.low_run = '0;
				s.high_run = '0;
			end
		end else begin
			if (level) begin
				if (s.high_run != COUNT_MAX) s.high_run++;
				if (s.high_run >= need) begin
					s.flag = 1'b0;
					s.high_run = '0;
				end
			end else begin
				s.phase = 1'b0;
				s.low_run = '0;
				s.high_run = '0;
			end
		end
		return s;
	endfunction

	// Advances the predicted state by one sample tick and returns the result
	// the block must report for it.
	function automatic tick_result_t controller_tick(input logic key, la, lb);
		logic [CNT_W-1:0] key_need;
		logic [CNT_W-1:0] sensor_need;
		tick_result_t     r;
		key_need = ticks_needed(key_ticks_cfg);
		sensor_need = ticks_needed(sensor_ticks_cfg);
		key_db = debounce_sample(key_db, key, key_need);
		limit_a_db = debounce_sample(limit_a_db, la, sensor_need);
		limit_b_db = debounce_sample(limit_b_db, lb, sensor_need);

		// A debounced press followed by a debounced release enables a run.
		if (!awaiting_release) begin
			if (key_db.flag) awaiting_release = 1'b1;
		end else if (!key_db.flag) begin
			running = 1'b1;
			awaiting_release = 1'b0;
		end

		// The run stops at the limit it heads for, possibly in the tick it
		// started, and the next run goes the other way.
		if (running && (heading_b ? limit_b_db.flag : limit_a_db.flag)) begin
			running = 1'b0;
			heading_b = !heading_b;
		end

		r.drive.forward = running && !heading_b;
		r.drive.reverse = running && heading_b;
		r.flags.key = key_db.flag;
		r.flags.limit_a = limit_a_db.flag;
		r.flags.limit_b = limit_b_db.flag;
		return r;
	endfunction

	task automatic report_error(input string msg);
		$display("[%0t] %s", $time, msg);
		error_count++;
	endtask

	task automatic check_bit(input string name, input logic got, input logic want);
		if (got !== want) report_error($sformatf("%s is %b, expected %b", name, got, want));
	endtask

	// Queues n equal samples. A glitchy stretch has one pin flipped at one
	// random place, which restarts that pin's count.
	task automatic hold_pins(input logic k, la, lb, input int unsigned n, input bit glitchy);
		int unsigned glitch_at;
		pin_sample_t s;
		glitch_at = glitchy ? $urandom_range(0, n - 1) : n;
		for (int unsigned i = 0; i < n; i++) begin
			s.key = k;
			s.limit_a = la;
			s.limit_b = lb;
			if (i == glitch_at) s[$urandom_range(0, 2)] ^= 1'b1;
			pending_samples.push_back(s);
			samples_queued++;
		end
	endtask

	// Returns once every queued sample has been transferred and its result
	// taken, followed by a settling wait.
	task automatic wait_until_drained();
		while (pending_samples.size() != 0 || expected_results.size() != 0 || in_valid)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes both thresholds and scribbles on the unused register indexes,
	// which the block must ignore.
	task automatic program_thresholds(input logic [CFG_W-1:0] key_ticks, sensor_ticks);
		wait_until_drained();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_KEY_TICKS;
		cfg_data <= key_ticks;
		@(posedge clk);
		cfg_index <= REG_SENSOR_TICKS;
		cfg_data <= sensor_ticks;
		for (int i = int'(REG_SENSOR_TICKS) + 1; i < 2 ** IDX_W; i++) begin
			@(posedge clk);
			cfg_index <= IDX_W'(i);
			cfg_data <= CFG_W'($urandom);
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		key_ticks_cfg = key_ticks;
		sensor_ticks_cfg = sensor_ticks;
	endtask

	// A full shuttle trip: press, release, then the limit the run should
	// head for goes active and clears again. Stretch lengths sit just at or
	// above the thresholds, and some stretches carry a glitch.
	task automatic queue_shuttle_trip(input int unsigned nk, ns);
		logic both;
		logic key_in_run;
		both = ($urandom_range(0, 7) == 0);
		key_in_run = ($urandom_range(0, 5) == 0);
		hold_pins(1'b0, 1'b1, 1'b1, nk + $urandom_range(0, 2), $urandom_range(0, 3) == 0);
		hold_pins(1'b1, 1'b1, 1'b1, nk + $urandom_range(0, 2), $urandom_range(0, 3) == 0);
		hold_pins(!key_in_run, aim_b && !both, !aim_b && !both, ns + $urandom_range(0, 2),
			$urandom_range(0, 3) == 0);
		hold_pins(1'b1, 1'b1, 1'b1, ns + $urandom_range(0, 2), $urandom_range(0, 3) == 0);
		aim_b = !aim_b;
	endtask

	// One random phase at fixed thresholds: mostly whole trips, some pin
	// noise and some presses cut short. It ends on a press that may be
	// partial, so the next phase can start with a count already running.
	task automatic run_phase(input logic [CFG_W-1:0] key_ticks, sensor_ticks,
			input int unsigned budget, input bit bursts);
		int unsigned first_queued;
		int unsigned nk;
		int unsigned ns;
		program_thresholds(key_ticks, sensor_ticks);
		idle_bursts <= bursts;
		nk = 32'(ticks_needed(key_ticks));
		ns = 32'(ticks_needed(sensor_ticks));
		first_queued = samples_queued;
		while (samples_queued - first_queued < budget) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					repeat ($urandom_range(1, 6))
						hold_pins(1'($urandom), 1'($urandom), 1'($urandom),
							$urandom_range(1, 3), 1'b0);
				end
				2: begin
					hold_pins(1'b0, 1'b1, 1'b1, $urandom_range(1, nk), 1'b0);
					hold_pins(1'b1, 1'b1, 1'b1, $urandom_range(1, nk), 1'b0);
				end
				default: queue_shuttle_trip(nk, ns);
			endcase
		end
		hold_pins(1'b0, 1'b1, 1'b1, $urandom_range(1, nk), 1'b0);
	endtask

	// Sender: offers queued samples, keeping the payload steady until the
	// transfer, and predicts each sample's result as it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			key_level <= 1'b1;
			limit_a_level <= 1'b1;
			limit_b_level <= 1'b1;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(controller_tick(key_level, limit_a_level,
					limit_b_level));
				samples_sent++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_samples.size() != 0) begin
					offered = pending_samples.pop_front();
					in_valid <= 1'b1;
					key_level <= offered.key;
					limit_a_level <= offered.limit_a;
					limit_b_level <= offered.limit_b;
					if (idle_bursts && $urandom_range(0, 5) == 0)
						send_gap = $urandom_range(1, 10);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: compares every result transfer with the oldest prediction
	// and stalls in random bursts or for the long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_error("result transfer with no sample outstanding");
				end else begin
					awaited = expected_results.pop_front();
					check_bit("drive_forward", drive_forward, awaited.drive.forward);
					check_bit("drive_reverse", drive_reverse, awaited.drive.reverse);
					check_bit("key_debounced", key_debounced, awaited.flags.key);
					check_bit("limit_a_active", limit_a_active, awaited.flags.limit_a);
					check_bit("limit_b_active", limit_b_active, awaited.flags.limit_b);
				end
			end
			if (hold_off) begin
				out_ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (idle_bursts && $urandom_range(0, 7) == 0)
					stall_left = $urandom_range(1, 10);
			end
		end
	end

	// Once, early in the run, the receiver stops taking results for a long
	// stretch while the sender keeps offering samples.
	initial begin
		while (samples_sent < HOLD_OFF_AT) @(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#5_000_000;
		$display("** debounced_shuttle_motor_controller: FAILED **");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// At the reset thresholds all three pins held low: the sensor flags
		// must set on the fifth sample and the key flag on the tenth.
		hold_pins(1'b0, 1'b0, 1'b0, 10, 1'b0);

		// Key threshold zero behaves as one; sensors at one.
		program_thresholds('0, CFG_W'(1));
		// Release: the flags clear and the first run goes forward.
		hold_pins(1'b1, 1'b1, 1'b1, 2, 1'b0);
		// Press during the run, still held when limit A stops it.
		hold_pins(1'b0, 1'b1, 1'b1, 2, 1'b0);
		hold_pins(1'b0, 1'b0, 1'b1, 2, 1'b0);
		// The held key is released and a reverse run starts, ended by limit B.
		hold_pins(1'b1, 1'b0, 1'b1, 1, 1'b0);
		hold_pins(1'b1, 1'b0, 1'b0, 2, 1'b0);
		// Another press and release with limit A already active: the forward
		// run ends in the tick it starts and never shows its drive.
		hold_pins(1'b0, 1'b0, 1'b0, 2, 1'b0);
		hold_pins(1'b1, 1'b0, 1'b0, 2, 1'b0);

		// Random phases, high thresholds before low ones so that a count left
		// running meets a lowered threshold.
		run_phase(KEY_TICKS_RST, SENSOR_TICKS_RST, 130, 1'b1);
		run_phase(CFG_W'(3), CFG_W'(2), 100, 1'b1);

		// Largest thresholds: all pins held low, then high, for the clamped counter maximum plus up to two samples.
		program_thresholds('1, '1);
		hold_pins(1'b0, 1'b0, 1'b0, int'(COUNT_MAX) + $urandom_range(0, 2), 1'b0);
		hold_pins(1'b1, 1'b1, 1'b1, int'(COUNT_MAX) + $urandom_range(0, 2), 1'b0);

		run_phase(CFG_W'(1), '0, 70, 1'b1);
		// The last stretch runs at full rate on both sides.
		run_phase('0, CFG_W'(3), 70, 1'b0);

		wait_until_drained();
		if (error_count == 0) begin
			$display("** debounced_shuttle_motor_controller: PASSED **");
		end else begin
			$display("** debounced_shuttle_motor_controller: FAILED **");
		end
		$finish;
	end

endmodule

// File: filelist.f
sv/dsmc_pkg.sv
sv/dsmc_debounce.sv
sv/dsmc_shuttle.sv
sv/debounced_shuttle_motor_controller.sv
tb/testbench.sv
